>>> src/qlfo_pkg.sv
// Shared types, constants and trigger helper for the quad linked LFO.
package qlfo_pkg;

    localparam int CHANNELS    = 4;
    localparam int CH_BITS     = 2;
    localparam int VOLT_BITS   = 17;
    localparam int KNOB_BITS   = 13;
    localparam int PERIOD_BITS = 24;
    localparam int OUT_BITS    = 15;
    localparam int MODE_BITS   = 3;
    localparam int IN_BYTES_W  = 144;
    localparam int OUT_BYTES_W = 64;
    localparam int CFG_IDX_W   = 3;

    // Mode codes
    localparam logic [MODE_BITS-1:0] MODE_FREE   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_QUAD   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_OFFSET = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DIV    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MUL    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 24'd89478;

    typedef logic signed [VOLT_BITS-1:0] t_volt;

    typedef enum logic [1:0] {
        TRIG_UNKNOWN = 2'd0,
        TRIG_LOW     = 2'd1,
        TRIG_HIGH    = 2'd2
    } t_trig;

    typedef struct packed {
        t_trig st;
        logic  fire;
    } t_trig_res;

    // One decoded tick handed from front to back
    typedef struct packed {
        logic [MODE_BITS-1:0]           mode;
        logic                           btn_fire;
        logic [CHANNELS-1:0][VOLT_BITS-1:0] cv;
        logic [CHANNELS-1:0][VOLT_BITS-1:0] gate;
    } t_job;

    function automatic logic volt_hi(input logic [VOLT_BITS-1:0] v);
        return $signed(v) >= 17'sd4096;
    endfunction

    function automatic logic volt_lo(input logic [VOLT_BITS-1:0] v);
        return $signed(v) <= 17'sd0;
    endfunction

    // Schmitt trigger: fires only on a low-to-high change
    function automatic t_trig_res trig_step(input t_trig st, input logic hi, input logic lo);
        t_trig_res res;
        res.st   = st;
        res.fire = 1'b0;
        unique case (st)
            TRIG_LOW: begin
                if (hi) begin
                    res.st   = TRIG_HIGH;
                    res.fire = 1'b1;
                end
            end
            TRIG_HIGH: begin
                if (lo) res.st = TRIG_LOW;
            end
            default: begin
                if (hi) res.st = TRIG_HIGH;
                else if (lo) res.st = TRIG_LOW;
            end
        endcase
        return res;
    endfunction

endpackage

>>> src/qlfo_front.sv
// Front end: takes input beats, tracks the mode button and queues decoded ticks.
module qlfo_front
    import qlfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_BYTES_W-1:0] i_s_tdata,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    t_trig                r_btn_st;
    logic [MODE_BITS-1:0] r_mode;
    t_trig_res            btn;
    logic [MODE_BITS-1:0] n_mode;
    logic                 button;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign button     = i_s_tdata[2*CHANNELS*VOLT_BITS];

    // Button edge steps the mode round
    always_comb begin
        btn    = trig_step(r_btn_st, button, !button);
        n_mode = r_mode;
        if (btn.fire) n_mode = (r_mode >= MODE_MUL) ? MODE_FREE : r_mode + 3'd1;
    end

    // Decode the beat
    always_comb begin
        o_job.mode     = n_mode;
        o_job.btn_fire = btn.fire;
        for (int c = 0; c < CHANNELS; c++) begin
            o_job.cv[c]   = i_s_tdata[c*VOLT_BITS +: VOLT_BITS];
            o_job.gate[c] = i_s_tdata[(CHANNELS+c)*VOLT_BITS +: VOLT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_st <= TRIG_UNKNOWN;
            r_mode   <= MODE_FREE;
        end else if (o_push) begin
            r_btn_st <= btn.st;
            r_mode   <= n_mode;
        end
    end

endmodule

>>> src/qlfo_queue.sv
// Two-entry queue of decoded ticks between front and back.
module qlfo_queue
    import qlfo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == (PTR_W+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_job;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

>>> src/qlfo_back.sv
// Back end: trigger and link work, then per channel exponential, phase step and waves.
module qlfo_back
    import qlfo_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [CHANNELS-1:0][KNOB_BITS-1:0]   i_knob,
    input  logic [PERIOD_BITS-1:0]               i_period,
    input  logic                                 i_job_valid,
    input  t_job                                 i_job,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [OUT_BYTES_W-1:0]               o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam int PB         = PHASE_BITS;
    localparam int STB        = SINE_TABLE_BITS;
    localparam int PROD_W     = 48;
    localparam int DIV_STEPS  = PROD_W / 8;
    localparam int SHIFT_BASE = 80 - PHASE_BITS;
    localparam logic [PB-1:0]    PHALF   = {1'b1, {(PB-1){1'b0}}};
    localparam logic [PB-1:0]    Q3      = {2'b11, {(PB-2){1'b0}}};
    localparam logic [STB-2:0]   QUARTER = {1'b1, {(STB-2){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_E0, S_E1, S_E2, S_M1, S_M2, S_DIV, S_INC,
        S_W0, S_W1, S_W2, S_W3, S_W4, S_W5
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [PB-1:0]       r_phase [CHANNELS];
    t_trig               r_rts   [CHANNELS];
    logic [CH_BITS-1:0]  r_ch;
    logic [11:0]         r_f;
    logic [5:0]          r_shift;
    logic [17:0]         r_t;
    logic [PROD_W-1:0]   r_prod;
    logic [3:0]          r_mul;
    logic [3:0]          r_div;
    logic [3:0]          r_rem;
    logic [2:0]          r_cnt;
    logic                r_noinc;
    logic [16:0]         r_x;
    logic [16:0]         r_s;
    logic [16:0]         r_p;
    logic                r_neg;
    logic                r_out_valid;
    logic [OUT_BYTES_W-1:0] r_out_data;
    logic                r_out_last;

    // Tick preparation: button resets, gates, phase links
    logic [PB-1:0]       p_ph [CHANNELS];
    t_trig               p_st [CHANNELS];
    t_trig_res           p_tr;
    logic [VOLT_BITS-1:0] p_g;

    always_comb begin
        p_tr = '0;
        p_g  = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            p_ph[c] = r_phase[c];
            p_st[c] = r_rts[c];
        end
        if (r_job.btn_fire) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (p_st[c] == TRIG_LOW) p_ph[c] = '0;
                p_st[c] = TRIG_HIGH;
            end
        end
        if (r_job.mode <= MODE_MUL) begin
            for (int c = 0; c < CHANNELS; c++) begin
                p_g  = (r_job.mode == MODE_FREE) ? r_job.gate[c] : r_job.gate[0];
                p_tr = trig_step(p_st[c], volt_hi(p_g), volt_lo(p_g));
                p_st[c] = p_tr.st;
                if (p_tr.fire) p_ph[c] = '0;
            end
        end
        if (r_job.mode == MODE_QUAD) begin
            for (int c = 1; c < CHANNELS; c++)
                p_ph[c] = p_ph[0] + (PB'(c) << (PB-2));
        end
        if (r_job.mode == MODE_OFFSET) begin
            for (int c = 1; c < CHANNELS; c++)
                p_ph[c] = p_ph[0] + PB'({i_knob[c], {(PB-12){1'b0}}});
        end
        if (r_job.mode == MODE_MUL && p_ph[0] == '0) begin
            for (int c = 1; c < CHANNELS; c++) begin
                if (p_st[c] == TRIG_LOW) p_ph[c] = '0;
                p_st[c] = TRIG_HIGH;
            end
        end
    end

    // Pitch, split into octave and fraction, and the frequency ratio
    logic [KNOB_BITS-1:0] e_knob;
    logic signed [16:0]   e_cv;
    logic signed [19:0]   e_pitch;
    logic [19:0]          e_uq;
    logic [24:0]          e_t0;
    logic [16:0]          e_rk;
    logic [4:0]           e_ratio_raw;
    logic [3:0]           e_ratio;

    always_comb begin
        e_knob  = (r_job.mode == MODE_FREE) ? i_knob[r_ch] : i_knob[0];
        e_cv    = (r_job.mode == MODE_FREE) ? r_job.cv[r_ch] : r_job.cv[0];
        e_pitch = $signed({7'd0, e_knob}) * 20'sd10 - 20'sd20480 + 20'(e_cv);
        if (e_pitch > 20'sd32768) e_pitch = 20'sd32768;
        e_uq    = 20'(e_pitch + 20'sd131072);
        e_t0    = (25'd5156 * 25'(e_uq[11:0])) >> 12;
        e_rk    = 17'(i_knob[r_ch]) * 17'd11 + 17'd2048;
        e_ratio_raw = 5'(e_rk >> 12) + 5'd1;
        e_ratio = (e_ratio_raw > 5'd12) ? 4'd12 : e_ratio_raw[3:0];
    end

    // Horner step of the mantissa polynomial
    logic [29:0] h_mt;
    assign h_mt = 30'(r_t) * 30'(r_f);

    // Divider: eight restoring steps per cycle by a small ratio
    logic [PROD_W-1:0] d_quo;
    logic [3:0]        d_rem;
    logic [4:0]        d_try;

    always_comb begin
        d_rem = r_rem;
        d_quo = r_prod;
        d_try = '0;
        for (int i = 0; i < 8; i++) begin
            d_try = {d_rem, d_quo[PROD_W-1]};
            d_quo = {d_quo[PROD_W-2:0], 1'b0};
            if (d_try >= {1'b0, r_div}) begin
                d_try    = d_try - {1'b0, r_div};
                d_quo[0] = 1'b1;
            end
            d_rem = d_try[3:0];
        end
    end

    // Phase step, limited to half a cycle
    logic [PROD_W-1:0] i_full_inc;
    logic [PB-1:0]     i_inc;
    logic [PB-1:0]     i_ph_new;

    always_comb begin
        i_full_inc = r_prod >> r_shift;
        if (r_noinc) i_inc = '0;
        else if (i_full_inc > PROD_W'(PHALF)) i_inc = PHALF;
        else i_inc = i_full_inc[PB-1:0];
        i_ph_new = r_phase[r_ch] + i_inc;
    end

    // Sine fold to a quarter wave
    logic [PB-1:0]  w_ph;
    logic [STB-1:0] w_idx;
    logic [STB-2:0] w_u;
    logic [16:0]    w_x;
    logic [33:0]    w_sq;
    logic [33:0]    w_ps;
    logic [24:0]    w_p1;

    always_comb begin
        w_ph  = r_phase[r_ch];
        w_idx = w_ph[PB-1 -: STB];
        w_u   = {1'b0, w_idx[STB-3:0]};
        if (w_idx[STB-2]) w_u = QUARTER - w_u;
        w_x   = 17'(w_u) << (18 - STB);
        w_sq  = 34'(w_x) * 34'(w_x);
        w_ps  = 34'(r_p) * 34'(r_s);
        w_p1  = 25'd307 * 25'(r_s);
    end

    // Final scaling and the three straight-line waves
    logic [31:0]             o_sc;
    logic [13:0]             o_v;
    logic signed [OUT_BITS-1:0] o_sine;
    logic [PB-1:0]           o_d;
    logic [PB-1:0]           o_a;
    logic [PB+15:0]          o_tp;
    logic [PB+15:0]          o_sp;
    logic signed [OUT_BITS-1:0] o_tri;
    logic signed [OUT_BITS-1:0] o_saw;
    logic signed [OUT_BITS-1:0] o_sqr;
    logic                    out_free;

    always_comb begin
        o_sc   = 32'(r_p) * 32'd10240 + 32'd32768;
        o_v    = ((o_sc >> 16) > 32'd10240) ? 14'd10240 : 14'(o_sc >> 16);
        o_sine = r_neg ? -$signed({1'b0, o_v}) : $signed({1'b0, o_v});
        o_d    = w_ph - Q3;
        o_a    = o_d[PB-1] ? (PB'(0) - o_d) : o_d;
        o_tp   = (PB+16)'(o_a) * (PB+16)'(40960);
        o_tri  = $signed(OUT_BITS'(o_tp >> PB)) - 15'sd10240;
        o_sp   = (PB+16)'(w_ph) * (PB+16)'(20480);
        o_saw  = $signed(OUT_BITS'(o_sp >> PB));
        if (w_ph[PB-1]) o_saw = o_saw - 15'sd20480;
        o_sqr  = w_ph[PB-1] ? -15'sd10240 : 15'sd10240;
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_pop      = (r_state == S_IDLE) && i_job_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // Sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= '0;
                r_rts[c]   <= TRIG_UNKNOWN;
            end
        end else begin
            // the result state loads its own beat
            if (i_m_tready && r_state != S_W5) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_phase[c] <= p_ph[c];
                        r_rts[c]   <= p_st[c];
                    end
                    r_ch    <= '0;
                    r_state <= S_E0;
                end
                S_E0: begin
                    r_f     <= e_uq[11:0];
                    r_shift <= 6'(SHIFT_BASE - int'(e_uq[17:12]));
                    r_t     <= 18'd14821 + 18'(e_t0);
                    r_noinc <= r_job.mode > MODE_MUL;
                    r_mul   <= (r_job.mode == MODE_MUL && r_ch != '0) ? e_ratio : 4'd1;
                    r_div   <= (r_job.mode == MODE_DIV && r_ch != '0) ? e_ratio : 4'd1;
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_t     <= 18'd45559 + h_mt[29:12];
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_t     <= 18'd65536 + h_mt[29:12];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_prod  <= PROD_W'(i_period) * PROD_W'(r_t);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod  <= r_prod * PROD_W'(r_mul);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= (r_div != 4'd1) ? S_DIV : S_INC;
                end
                S_DIV: begin
                    r_prod <= d_quo;
                    r_rem  <= d_rem;
                    r_cnt  <= r_cnt + 3'd1;
                    if (r_cnt == 3'(DIV_STEPS-1)) r_state <= S_INC;
                end
                S_INC: begin
                    r_phase[r_ch] <= i_ph_new;
                    r_state       <= S_W0;
                end
                S_W0: begin
                    r_x     <= w_x;
                    r_s     <= 17'(w_sq >> 16);
                    r_neg   <= w_idx[STB-1];
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_p     <= 17'd5223 - 17'(w_p1 >> 16);
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_p     <= 17'd42334 - 17'(w_ps >> 16);
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_p     <= 17'd102944 - 17'(w_ps >> 16);
                    r_state <= S_W4;
                end
                S_W4: begin
                    r_p     <= 17'((34'(r_p) * 34'(r_x)) >> 16);
                    r_state <= S_W5;
                end
                S_W5: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, o_sqr, o_saw, o_tri, o_sine, r_ch};
                        r_out_last  <= r_ch == CH_BITS'(CHANNELS-1);
                        r_ch        <= r_ch + 1'b1;
                        r_state     <= (r_ch == CH_BITS'(CHANNELS-1)) ? S_IDLE : S_E0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/quad_linked_lfo.sv
// Quad linked LFO top level: configuration registers, front, queue and back.
//
// Input stream: one beat per sample tick carrying four pitch CVs, four reset
// gates and the mode button level. Output stream: four beats per tick, one per
// oscillator in order 0..3, each with sine, triangle, saw and square values;
// tlast marks the channel 3 beat.
// The front takes a beat whenever the two-entry tick queue has room, so up to
// two ticks can wait while the back is busy.
// The back does trigger and phase-link work once per tick, then works through
// each channel in turn (exponential, phase add, sine polynomial), adding a
// restoring divider when the channel's rate is divided by a ratio. It takes
// the next tick from the queue only once it has finished the last one. The
// back is the limit on throughput.
// Configuration writes are registered and should be made while idle.
// Reset (synchronous, active low) zeroes the phases and mode, sets the knobs to
// zero and the sample period to its default, and leaves the triggers unknown.
// A stalled output holds its beat; the back then waits with the next result
// and the queue fills before tready drops on the input.
module quad_linked_lfo
    import qlfo_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // cv0..cv3, gate0..gate3 (17 bits each), mode_button, zero fill
    input  logic [IN_BYTES_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // channel, sine_out, triangle_out, saw_out, square_out, zero fill
    output logic [OUT_BYTES_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [PERIOD_BITS-1:0] i_cfg_data
);

    logic [CHANNELS-1:0][KNOB_BITS-1:0] r_knob;
    logic [PERIOD_BITS-1:0]             r_period;
    logic                               push;
    logic                               full;
    logic                               job_valid;
    logic                               pop;
    t_job                               push_job;
    t_job                               head_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob   <= '0;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KNOB_0: r_knob[0] <= i_cfg_data[KNOB_BITS-1:0];
                CFG_KNOB_1: r_knob[1] <= i_cfg_data[KNOB_BITS-1:0];
                CFG_KNOB_2: r_knob[2] <= i_cfg_data[KNOB_BITS-1:0];
                CFG_KNOB_3: r_knob[3] <= i_cfg_data[KNOB_BITS-1:0];
                CFG_PERIOD: r_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qlfo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    qlfo_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .o_valid    (job_valid),
        .i_pop      (pop),
        .o_job      (head_job)
    );

    qlfo_back #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_knob      (r_knob),
        .i_period    (r_period),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Last beat of a tick belongs to channel 3
    a_last_ch3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[1:0] == 2'd3)
        else $error("last beat not on channel 3");

    // Square is always full scale
    a_sqr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[61:47] == 15'd10240 || o_m_tdata[61:47] == 15'h5800))
        else $error("square not at full scale");

    // Sine is not negative in the first half cycle
    a_sine_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[61:47] == 15'd10240 |-> !o_m_tdata[16])
        else $error("sine sign disagrees with square");

endmodule
